// File: design/sdit_pkg.sv
// Shared types and constants for the Sampson distance inlier test core.
`default_nettype none
package sdit_pkg;

    localparam int CoefW   = 21;
    localparam int RowW    = 63;
    localparam int DistW   = 32;
    localparam int CoordW  = 16;
    localparam int CfgAddrW = 2;
    localparam int VecW    = 39;  // signed F*p components, below 2^38
    localparam int MagW    = 38;
    localparam int MagHalfW = 19; // half of a magnitude, squared in pieces
    localparam int SqW     = 76;  // square of one magnitude
    localparam int ResW    = 57;  // signed residual
    localparam int NHalfW  = 28;  // half of the residual magnitude
    localparam int NPartW  = 56;  // product of two residual halves
    localparam int NumW    = 112; // n^2
    localparam int DenW    = 80;  // sum of four squares
    localparam int QW      = 33;  // quotient bits tried: 2^32 means saturate
    localparam int QDepth  = 8;
    localparam int QPtrW   = 3;

    localparam logic [CfgAddrW-1:0] REG_ROW_TOP    = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_ROW_MIDDLE = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_ROW_BOTTOM = 2'd2;
    localparam logic [CfgAddrW-1:0] REG_THRESHOLD  = 2'd3;

    localparam logic [DistW-1:0] ThresholdReset = 32'd25600;
    localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

    typedef struct packed {
        logic [CoordW-1:0] first_x;
        logic [CoordW-1:0] first_y;
        logic [CoordW-1:0] second_x;
        logic [CoordW-1:0] second_y;
    } in_item_t;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic             inlier;
        logic             degenerate;
    } out_item_t;

    // front to back: numerator and denominator of one item
    typedef struct packed {
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } frac_t;

    function automatic logic signed [CoefW-1:0] coef(input logic [RowW-1:0] row,
                                                     input int col);
        coef = row[col*CoefW +: CoefW];
    endfunction

endpackage
`default_nettype wire

// File: design/sdit_front.sv
// Front pipeline: forms F*p0, F^T*p1, residual and the numerator/denominator.
`default_nettype none
module sdit_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_fire,
    input  wire sdit_pkg::in_item_t       item,
    input  wire logic [sdit_pkg::RowW-1:0] row0,
    input  wire logic [sdit_pkg::RowW-1:0] row1,
    input  wire logic [sdit_pkg::RowW-1:0] row2,
    output logic                          out_valid,
    output sdit_pkg::frac_t               frac
);
    // stage 1: vectors a and b; p1 kept for residual
    logic signed [sdit_pkg::VecW-1:0] a0_reg, a1_reg, a2_reg, b0_reg, b1_reg;
    logic [sdit_pkg::CoordW-1:0] sx_reg, sy_reg;
    // stage 2: residual, magnitudes of a0, a1, b0, b1
    logic signed [sdit_pkg::ResW-1:0] n_reg;
    logic [sdit_pkg::MagW-1:0] m_reg [4];
    // stage 3: half-width partial products of the squares
    logic [sdit_pkg::NPartW-1:0] nhh_reg, nhl_reg, nll_reg;
    logic [sdit_pkg::MagW-1:0] mhh_reg [4];
    logic [sdit_pkg::MagW-1:0] mhl_reg [4];
    logic [sdit_pkg::MagW-1:0] mll_reg [4];
    // stage 4: squares
    logic [sdit_pkg::NumW-1:0] nn_reg;
    logic [sdit_pkg::SqW-1:0] s_reg [4];
    // stage 5: sum
    logic [sdit_pkg::NumW-1:0] num_reg;
    logic [sdit_pkg::DenW-1:0] den_reg;
    logic [4:0] v_reg;

    logic signed [sdit_pkg::VecW-1:0] p0x, p0y, p1x, p1y, one;
    logic signed [sdit_pkg::VecW-1:0] f [3][3];
    logic signed [sdit_pkg::ResW-1:0] n_next;
    logic [sdit_pkg::ResW-1:0] nabs;
    logic [sdit_pkg::NHalfW-1:0] nhi, nlo;
    logic [sdit_pkg::MagHalfW-1:0] mhi [4];
    logic [sdit_pkg::MagHalfW-1:0] mlo [4];

    function automatic logic [sdit_pkg::MagW-1:0] mag(
        input logic signed [sdit_pkg::VecW-1:0] v);
        logic [sdit_pkg::VecW-1:0] u;
        u = v[sdit_pkg::VecW-1] ? -v : v;
        mag = u[sdit_pkg::MagW-1:0];
    endfunction

    always_comb
    begin
        p0x = sdit_pkg::VecW'($unsigned(item.first_x));
        p0y = sdit_pkg::VecW'($unsigned(item.first_y));
        p1x = sdit_pkg::VecW'($unsigned(item.second_x));
        p1y = sdit_pkg::VecW'($unsigned(item.second_y));
        one = sdit_pkg::VecW'(16);
        for (int j = 0; j < 3; j++)
        begin
            f[0][j] = sdit_pkg::VecW'(sdit_pkg::coef(row0, j));
            f[1][j] = sdit_pkg::VecW'(sdit_pkg::coef(row1, j));
            f[2][j] = sdit_pkg::VecW'(sdit_pkg::coef(row2, j));
        end
    end

    always_comb
    begin
        n_next = sdit_pkg::ResW'(a0_reg) * sdit_pkg::ResW'($signed({1'b0, sx_reg}))
               + sdit_pkg::ResW'(a1_reg) * sdit_pkg::ResW'($signed({1'b0, sy_reg}))
               + sdit_pkg::ResW'(a2_reg) * sdit_pkg::ResW'(16);
    end

    // squares are built from halves: x^2 = hi^2 << 2h + 2*hi*lo << h + lo^2
    always_comb
    begin
        nabs = n_reg[sdit_pkg::ResW-1] ? -n_reg : n_reg;
        nhi  = nabs[sdit_pkg::NPartW-1:sdit_pkg::NHalfW];
        nlo  = nabs[sdit_pkg::NHalfW-1:0];
        for (int i = 0; i < 4; i++)
        begin
            mhi[i] = m_reg[i][sdit_pkg::MagW-1:sdit_pkg::MagHalfW];
            mlo[i] = m_reg[i][sdit_pkg::MagHalfW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_fire};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= f[0][0]*p0x + f[0][1]*p0y + f[0][2]*one;
            a1_reg <= f[1][0]*p0x + f[1][1]*p0y + f[1][2]*one;
            a2_reg <= f[2][0]*p0x + f[2][1]*p0y + f[2][2]*one;
            b0_reg <= f[0][0]*p1x + f[1][0]*p1y + f[2][0]*one;
            b1_reg <= f[0][1]*p1x + f[1][1]*p1y + f[2][1]*one;
            sx_reg <= item.second_x;
            sy_reg <= item.second_y;
            n_reg  <= n_next;
            m_reg[0] <= mag(a0_reg);
            m_reg[1] <= mag(a1_reg);
            m_reg[2] <= mag(b0_reg);
            m_reg[3] <= mag(b1_reg);
            nhh_reg <= {sdit_pkg::NHalfW'(0), nhi} * {sdit_pkg::NHalfW'(0), nhi};
            nhl_reg <= {sdit_pkg::NHalfW'(0), nhi} * {sdit_pkg::NHalfW'(0), nlo};
            nll_reg <= {sdit_pkg::NHalfW'(0), nlo} * {sdit_pkg::NHalfW'(0), nlo};
            for (int i = 0; i < 4; i++)
            begin
                mhh_reg[i] <= {sdit_pkg::MagHalfW'(0), mhi[i]}
                            * {sdit_pkg::MagHalfW'(0), mhi[i]};
                mhl_reg[i] <= {sdit_pkg::MagHalfW'(0), mhi[i]}
                            * {sdit_pkg::MagHalfW'(0), mlo[i]};
                mll_reg[i] <= {sdit_pkg::MagHalfW'(0), mlo[i]}
                            * {sdit_pkg::MagHalfW'(0), mlo[i]};
                s_reg[i] <= (sdit_pkg::SqW'(mhh_reg[i]) << (2*sdit_pkg::MagHalfW))
                          + (sdit_pkg::SqW'(mhl_reg[i]) << (sdit_pkg::MagHalfW+1))
                          + sdit_pkg::SqW'(mll_reg[i]);
            end
            nn_reg <= (sdit_pkg::NumW'(nhh_reg) << (2*sdit_pkg::NHalfW))
                    + (sdit_pkg::NumW'(nhl_reg) << (sdit_pkg::NHalfW+1))
                    + sdit_pkg::NumW'(nll_reg);
            num_reg <= nn_reg;
            den_reg <= sdit_pkg::DenW'(s_reg[0]) + sdit_pkg::DenW'(s_reg[1])
                     + sdit_pkg::DenW'(s_reg[2]) + sdit_pkg::DenW'(s_reg[3]);
        end
    end

    assign out_valid = v_reg[4];
    assign frac.num  = num_reg;
    assign frac.den  = den_reg;
endmodule
`default_nettype wire

// File: design/sdit_queue.sv
// Short item queue between front and back.
`default_nettype none
module sdit_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sdit_pkg::frac_t  din,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [sdit_pkg::QPtrW:0] count,
    output sdit_pkg::frac_t       dout
);
    sdit_pkg::frac_t mem_reg [sdit_pkg::QDepth];
    logic [sdit_pkg::QPtrW-1:0] wr_reg, rd_reg;
    logic [sdit_pkg::QPtrW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {sdit_pkg::QPtrW'(0), push} - {sdit_pkg::QPtrW'(0), pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= din;
    end

    assign not_empty = cnt_reg != '0;
    assign count = cnt_reg;
    assign dout = mem_reg[rd_reg];
endmodule
`default_nettype wire

// File: design/sdit_back.sv
// Back pipeline: restoring division one quotient bit a stage, then flags.
`default_nettype none
module sdit_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_fire,
    input  wire sdit_pkg::frac_t          frac,
    input  wire logic [sdit_pkg::DistW-1:0] threshold,
    output logic                          out_valid,
    output sdit_pkg::out_item_t           item
);
    localparam int N = sdit_pkg::QW;
    logic [sdit_pkg::NumW-1:0] rem_reg [N+1];
    logic [sdit_pkg::DenW-1:0] den_reg [N+1];
    logic [N-1:0]              q_reg   [N+1];
    logic [N:0]                v_reg;
    sdit_pkg::out_item_t       res_reg;
    logic                      rv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            rv_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[N-1:0], in_fire};
            rv_reg <= v_reg[N];
        end
    end

    // stage k tries bit N-1-k: compare rem with den << bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= frac.num;
            den_reg[0] <= frac.den;
            q_reg[0]   <= '0;
            for (int k = 0; k < N; k++)
            begin
                logic [sdit_pkg::NumW+N-1:0] t;
                t = {{N{1'b0}}, sdit_pkg::NumW'(den_reg[k])} << (N-1-k);
                den_reg[k+1] <= den_reg[k];
                if ({{N{1'b0}}, rem_reg[k]} >= t)
                begin
                    rem_reg[k+1] <= rem_reg[k] - t[sdit_pkg::NumW-1:0];
                    q_reg[k+1]   <= q_reg[k] | (N'(1) << (N-1-k));
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
            end
            begin
                logic dg;
                logic [sdit_pkg::DistW-1:0] d;
                dg = den_reg[N] == '0;
                d  = (dg || q_reg[N][N-1]) ? sdit_pkg::DistMax
                                           : q_reg[N][sdit_pkg::DistW-1:0];
                res_reg.distance   <= d;
                res_reg.degenerate <= dg;
                res_reg.inlier     <= !dg && (d <= threshold);
            end
        end
    end

    assign out_valid = rv_reg;
    assign item = res_reg;
endmodule
`default_nettype wire

// File: design/sampson_distance_inlier_test_core.sv
// Top level of the Sampson distance inlier test core.
// Takes one correspondence per cycle. Front pipeline (5 stages) forms the
// epipolar residual and Sampson denominator, squaring in half-width pieces over
// two stages; an 8-entry queue decouples it from the back pipeline, a 33-stage
// restoring divider (one quotient bit per stage) plus one flag stage. Sustained
// rate is one item per cycle: an item holds one of the 8 queue places from
// acceptance until it leaves the queue, and without back-pressure fewer than 8
// places are ever held, so the limit never bites.
// The back pipeline stops while out_stall holds a valid result. The front
// always runs, so in_stall rises once items in the front plus items in the
// queue reach 8.
`default_nettype none
module sampson_distance_inlier_test_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [62:0]             cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire sdit_pkg::in_item_t      in_item,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output sdit_pkg::out_item_t          out_item
);
    logic [sdit_pkg::RowW-1:0]  row0_reg, row1_reg, row2_reg;
    logic [sdit_pkg::DistW-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= '0;
            row1_reg <= '0;
            row2_reg <= '0;
            thr_reg  <= sdit_pkg::ThresholdReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdit_pkg::REG_ROW_TOP:    row0_reg <= cfg_data;
                sdit_pkg::REG_ROW_MIDDLE: row1_reg <= cfg_data;
                sdit_pkg::REG_ROW_BOTTOM: row2_reg <= cfg_data;
                sdit_pkg::REG_THRESHOLD:  thr_reg  <= cfg_data[sdit_pkg::DistW-1:0];
                default: ;
            endcase
        end
    end

    // Front cannot be held, so every item in it must already own a queue
    // place: count the items in the front stages beside the queue fill.
    logic                 f_valid;
    sdit_pkg::frac_t      f_frac;
    logic                 q_ne, q_pop, b_en, f_en, in_fire;
    logic [sdit_pkg::QPtrW:0] q_cnt;
    sdit_pkg::frac_t      q_dout;
    logic [2:0]           fly_reg;

    // front is free-running; it accepts while queue + in flight < depth
    assign f_en     = 1'b1;
    assign in_stall = ({1'b0, q_cnt} + 5'(fly_reg)) >= 5'(sdit_pkg::QDepth);
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fly_reg <= '0;
        else
            fly_reg <= fly_reg + {2'b0, in_fire} - {2'b0, f_valid};
    end

    sdit_front u_front (
        .clk(clk), .rst_n(rst_n), .en(f_en), .in_fire(in_fire), .item(in_item),
        .row0(row0_reg), .row1(row1_reg), .row2(row2_reg),
        .out_valid(f_valid), .frac(f_frac)
    );

    assign b_en  = !(out_valid && out_stall);
    assign q_pop = q_ne && b_en;

    sdit_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .din(f_frac), .pop(q_pop),
        .not_empty(q_ne), .count(q_cnt), .dout(q_dout)
    );

    sdit_back u_back (
        .clk(clk), .rst_n(rst_n), .en(b_en), .in_fire(q_pop), .frac(q_dout),
        .threshold(thr_reg), .out_valid(out_valid), .item(out_item)
    );
endmodule
`default_nettype wire

// File: verif/sdit_scoreboard.sv
// Checker for the Sampson distance core: mirrors the registers, predicts and compares each result.
`default_nettype none
module sdit_scoreboard (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [62:0]          cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire sdit_pkg::in_item_t   in_item,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire sdit_pkg::out_item_t  out_item,
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [sdit_pkg::RowW-1:0]  f_rows [3];
    logic [sdit_pkg::DistW-1:0] threshold;
    sdit_pkg::out_item_t        expected_q [$];
    int                         mismatches = 0;

    function automatic sdit_pkg::out_item_t sampson_predict(sdit_pkg::in_item_t it);
        longint signed      f [3][3];
        longint signed      p0 [3];
        longint signed      p1 [3];
        longint signed      a [3];
        longint signed      b [3];
        longint signed      resid;
        logic signed [sdit_pkg::CoefW-1:0] c;
        logic [63:0]        m;
        logic [127:0]       num;
        logic [127:0]       den;
        logic [127:0]       quot;
        sdit_pkg::out_item_t r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                c = f_rows[i][j*sdit_pkg::CoefW +: sdit_pkg::CoefW];
                f[i][j] = c;
            end
        p0[0] = longint'(it.first_x);
        p0[1] = longint'(it.first_y);
        p0[2] = 16;
        p1[0] = longint'(it.second_x);
        p1[1] = longint'(it.second_y);
        p1[2] = 16;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = 0;
            b[i] = 0;
            for (int j = 0; j < 3; j++)
            begin
                a[i] += f[i][j] * p0[j];
                b[i] += f[j][i] * p1[j];
            end
        end
        resid = p1[0] * a[0] + p1[1] * a[1] + p1[2] * a[2];
        m = (resid < 0) ? 64'(-resid) : 64'(resid);
        num = {64'd0, m} * {64'd0, m};
        den = '0;
        for (int i = 0; i < 2; i++)
        begin
            m = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
            den += {64'd0, m} * {64'd0, m};
            m = (b[i] < 0) ? 64'(-b[i]) : 64'(b[i]);
            den += {64'd0, m} * {64'd0, m};
        end
        r.degenerate = (den == 0);
        if (r.degenerate)
            r.distance = sdit_pkg::DistMax;
        else
        begin
            quot = num / den;
            r.distance = (quot[127:32] != 0) ? sdit_pkg::DistMax : quot[31:0];
        end
        r.inlier = !r.degenerate && (r.distance <= threshold);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_rows[0] <= '0;
            f_rows[1] <= '0;
            f_rows[2] <= '0;
            threshold <= sdit_pkg::ThresholdReset;
        end
        else
        begin
            // config only moves while idle, so prediction sees the settled values
            if (in_valid && !in_stall)
                expected_q.push_back(sampson_predict(in_item));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: dist=%0d inl=%0b deg=%0b",
                                 out_item.distance, out_item.inlier, out_item.degenerate);
                end
                else
                begin
                    sdit_pkg::out_item_t e;
                    e = expected_q.pop_front();
                    if (e.distance !== out_item.distance || e.inlier !== out_item.inlier
                        || e.degenerate !== out_item.degenerate)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp dist=%0d inl=%0b deg=%0b,",
                                      " got dist=%0d inl=%0b deg=%0b"},
                                     e.distance, e.inlier, e.degenerate, out_item.distance,
                                     out_item.inlier, out_item.degenerate);
                    end
                end
            end
            if (cfg_we)
                case (cfg_index)
                    sdit_pkg::REG_ROW_TOP:    f_rows[0] <= cfg_data;
                    sdit_pkg::REG_ROW_MIDDLE: f_rows[1] <= cfg_data;
                    sdit_pkg::REG_ROW_BOTTOM: f_rows[2] <= cfg_data;
                    sdit_pkg::REG_THRESHOLD:  threshold <= cfg_data[sdit_pkg::DistW-1:0];
                    default: ;
                endcase
            // leftovers at the end count as failures
            outstanding = expected_q.size();
            fail_count  = mismatches + expected_q.size();
        end
    end
endmodule
`default_nettype wire

// File: verif/sampson_distance_inlier_test_core_test.sv
// Testbench top for the Sampson distance core: stimulus, register writes and verdict.
`default_nettype none
module sampson_distance_inlier_test_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 60;   // drain time beyond the pipeline

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = sdit_pkg::REG_ROW_TOP;
    logic [62:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    sdit_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    sdit_pkg::out_item_t out_item;
    int         fail_count;
    int         outstanding;
    int         send_idle_pct = 0;   // chance per cycle the sender holds off
    int         recv_stall_pct = 0;  // chance per cycle the receiver stalls
    int         cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sampson_distance_inlier_test_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    sdit_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // receiver back-pressure, redrawn every falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("sampson_distance_inlier_test_core_test failed");
            $finish;
        end
    end

    function automatic logic [62:0] pack_row(int c0, int c1, int c2);
        return {c2[sdit_pkg::CoefW-1:0], c1[sdit_pkg::CoefW-1:0], c0[sdit_pkg::CoefW-1:0]};
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [62:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // presents one item and returns once it has been taken
    task automatic send_corr(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1, logic [15:0] y1);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{first_x: x0, first_y: y0, second_x: x1, second_y: y1};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid and let the pipeline empty before touching registers
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // matrix of a pure sideways shift: n ~ c*(y0 - y1), inliers when the rows agree
    task automatic load_shift_matrix(int c);
        write_reg(sdit_pkg::REG_ROW_TOP, pack_row(0, 0, 0));
        write_reg(sdit_pkg::REG_ROW_MIDDLE, pack_row(0, 0, -c));
        write_reg(sdit_pkg::REG_ROW_BOTTOM, pack_row(0, c, 0));
    endtask

    task automatic load_random_matrix(logic [62:0] noise_mask);
        write_reg(sdit_pkg::REG_ROW_TOP, 63'({$urandom, $urandom}) & noise_mask);
        write_reg(sdit_pkg::REG_ROW_MIDDLE, 63'({$urandom, $urandom}) & noise_mask);
        write_reg(sdit_pkg::REG_ROW_BOTTOM, 63'({$urandom, $urandom}));
    endtask

    initial
    begin
        logic [15:0] x0, y0, x1, y1;
        int          k;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset matrix is all zero: every item is degenerate
        send_corr(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_corr(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        // shift matrix, extreme coordinates, threshold at its top
        load_shift_matrix(20'h80000 - 1);
        write_reg(sdit_pkg::REG_THRESHOLD, 63'h7FFF_FFFF_FFFF_FFFF);
        send_corr(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_corr(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_corr(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_corr(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_corr(16'h1234, 16'h0100, 16'h4321, 16'h0101);
        settle();

        // most negative coefficients, threshold zero: exact matches only
        load_shift_matrix(-(1 << 20));
        write_reg(sdit_pkg::REG_THRESHOLD, 63'd0);
        send_corr(16'h0400, 16'h0200, 16'h0800, 16'h0200);
        send_corr(16'h0400, 16'h0200, 16'h0800, 16'h0201);
        send_corr(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        settle();

        // dense fixed-pattern matrix: saturating and general quotients
        write_reg(sdit_pkg::REG_ROW_TOP, 63'h7FFF_FFFF_FFFF_FFFF);
        write_reg(sdit_pkg::REG_ROW_MIDDLE, 63'h2AAA_AAAA_AAAA_AAAA);
        write_reg(sdit_pkg::REG_ROW_BOTTOM, 63'h5555_5555_5555_5555);
        write_reg(sdit_pkg::REG_THRESHOLD, {31'h7FFF_FFFF, 32'd25600});
        send_corr(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_corr(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        settle();

        // random phases: first receiver-heavy stalling, then sender-heavy idling, then none
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 35;
                recv_stall_pct = 58;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 58;
                recv_stall_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            settle();
            if (phase % 2 == 0)
                load_shift_matrix(int'($urandom_range(1, 20'hFFFFF))
                                  - (1 << 20) * int'($urandom_range(0, 1)));
            else
                load_random_matrix(phase == 1 ? 63'h0000_0FFF_FFFF_FFFF : '1);
            case (phase % 4)
                0: write_reg(sdit_pkg::REG_THRESHOLD, 63'(sdit_pkg::DistMax));
                1: write_reg(sdit_pkg::REG_THRESHOLD, 63'd0);
                default: write_reg(sdit_pkg::REG_THRESHOLD,
                                   63'({$urandom, $urandom} >> $urandom_range(31, 62)));
            endcase
            for (k = 0; k < 180; k++)
            begin
                x0 = 16'($urandom);
                y0 = 16'($urandom);
                if ($urandom_range(99) < 60)
                begin
                    // matched pair: same row give or take 32 sixteenths
                    x1 = 16'($urandom);
                    y1 = y0 + 16'($signed($urandom_range(0, 64)) - 32);
                end
                else
                begin
                    x1 = 16'($urandom);
                    y1 = 16'($urandom);
                end
                send_corr(x0, y0, x1, y1);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("sampson_distance_inlier_test_core_test passed");
        else
            $display("sampson_distance_inlier_test_core_test failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
design/sdit_pkg.sv
design/sdit_front.sv
design/sdit_queue.sv
design/sdit_back.sv
design/sampson_distance_inlier_test_core.sv
verif/sdit_scoreboard.sv
verif/sampson_distance_inlier_test_core_test.sv
